/* hw/rtl/ordered_list_insert_delete_defines.svh */
// ----------------------------------------------------------------------------
// ordered list assertion macros
// shared property wrappers for the ordered list insert/delete block
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OLID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olid assertion failed");

// next-cycle implication, disabled in reset
`define OLID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olid assertion failed");

`endif

/* hw/rtl/olid_pkg.sv */
// ----------------------------------------------------------------------------
// olid_pkg
// constants, codes and types shared by the ordered list cells and sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package olid_pkg;

  // list geometry
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  // field widths
  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 8;
  localparam int FOUND_W = 7;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;

  // stream widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [OP_W-1:0] OP_GET    = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // cell modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    logic [1:0]        mode;
    logic [CMP_W-1:0]  pos;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

  // result of one operation
  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [FOUND_W-1:0] found;
    logic [WORD_W-1:0]  rd;
    logic [LEN_W-1:0]   len;
    logic               empty;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/olid_cell.sv */
// ----------------------------------------------------------------------------
// olid_cell
// one list entry: holds, opens a gap, closes a gap or rotates toward the head
// ----------------------------------------------------------------------------
`default_nettype none

module olid_cell
  import olid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire cell_cmd_t         cmd,
  input  wire logic [WORD_W-1:0] left_data,
  input  wire logic [WORD_W-1:0] right_data,
  output logic      [WORD_W-1:0] data_o
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic [CMP_W-1:0]  idx_ext;

  assign idx_ext = CMP_W'(idx);

  // next entry value from the broadcast command
  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      MODE_HOLD: data_nxt = data_r;
      MODE_INSERT: begin
        if (idx_ext > cmd.pos) begin
          data_nxt = left_data;
        end else if (idx_ext == cmd.pos) begin
          data_nxt = cmd.value;
        end
      end
      MODE_DELETE: begin
        if (idx_ext >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      MODE_ROTATE: data_nxt = right_data;
      default: data_nxt = data_r;
    endcase
  end

  // entry storage, payload only
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

/* hw/rtl/olid_ctrl.sv */
// ----------------------------------------------------------------------------
// olid_ctrl
// operation sequencer: length, range checks, head scan for locate and get
// ----------------------------------------------------------------------------
`default_nettype none

module olid_ctrl
  import olid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [POS_W-1:0]  in_pos,
  input  wire logic [WORD_W-1:0] in_value,
  input  wire logic [WORD_W-1:0] head,
  input  wire logic              out_free,
  output cell_cmd_t              cmd,
  output logic                   res_valid,
  output res_t                   res,
  output logic [CNT_W-1:0]       list_len
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r,  state_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [IDX_W-1:0]  step_r,   step_nxt;
  logic [OP_W-1:0]   op_r,     op_nxt;
  logic [CMP_W-1:0]  pos_r,    pos_nxt;
  logic [WORD_W-1:0] val_r,    val_nxt;
  logic              hit_r,    hit_nxt;
  logic [IDX_W-1:0]  found_r,  found_nxt;
  logic [WORD_W-1:0] rd_r,     rd_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             head_match;

  assign in_ready = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign accept   = in_valid && in_ready;
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(cnt_r);

  // head entry matches the search word and lies inside the list
  assign head_match = (head == val_r) && (CNT_W'(step_r) < cnt_r);

  // sequencer next state and cell command
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    cmd.mode   = MODE_HOLD;
    cmd.pos    = pos_ext;
    cmd.value  = in_value;

    if ((state_r == S_DONE) && out_free) begin
      state_nxt = S_IDLE;
    end

    // head scan: the chain rotates once round, one entry past the head a cycle
    if (state_r == S_SCAN) begin
      cmd.mode = MODE_ROTATE;
      if ((op_r == OP_LOCATE) && !hit_r && head_match) begin
        hit_nxt   = 1'b1;
        found_nxt = step_r;
      end
      if ((op_r == OP_GET) && (CMP_W'(step_r) == pos_r)) begin
        rd_nxt = head;
      end
      if (step_r == IDX_W'(CAPACITY - 1)) begin
        state_nxt = S_DONE;
        if (op_r == OP_GET) begin
          status_nxt = ST_OK;
        end else begin
          status_nxt = hit_nxt ? ST_OK : ST_NOT_FOUND;
        end
      end else begin
        step_nxt = step_r + IDX_W'(1);
      end
    end

    // new operation
    if (accept) begin
      state_nxt  = S_DONE;
      step_nxt   = '0;
      op_nxt     = in_op;
      pos_nxt    = pos_ext;
      val_nxt    = in_value;
      hit_nxt    = 1'b0;
      found_nxt  = '0;
      rd_nxt     = '0;
      status_nxt = ST_OK;
      unique case (in_op)
        OP_CLEAR: cnt_nxt = '0;
        OP_INSERT: begin
          if (cnt_r >= CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            status_nxt = ST_BAD_POS;
          end else begin
            cmd.mode = MODE_INSERT;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = ST_BAD_POS;
          end else begin
            cmd.mode = MODE_DELETE;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        OP_LOCATE: begin
          if (cnt_r == '0) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
        OP_GET: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = ST_BAD_POS;
          end else begin
            state_nxt = S_SCAN;
          end
        end
        default: status_nxt = ST_BAD_POS;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    found_r  <= found_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
  end

  // result view, length taken from the count left by this operation
  assign res_valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.found  = FOUND_W'(found_r);
  assign res.rd     = rd_r;
  assign res.len    = LEN_W'(cnt_r);
  assign res.empty  = (cnt_r == '0);
  assign list_len   = cnt_r;

endmodule

`default_nettype wire

/* hw/rtl/ordered_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// ordered list of signed words held in a chain of entry cells
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  in_     | in  | position[7:0], value[39:8]                  | op[2:0]
//  out_    | out | found_position[6:0], read_value[38:7],
//          |     | list_length[46:39], is_empty[47]            | status[1:0]
//
//  clear, insert, delete and rejected operations: result registered in the
//  sequencer, then in the output register; a new beat every cycle while the
//  output drains. locate and get: one full rotation of the cell chain past
//  the head cell; no input beat is taken during the rotation.
//  reset clears the length and the handshake state, not the entries; a stalled
//  output holds one result there and one in the sequencer before input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_insert_delete_defines.svh"

module ordered_list_insert_delete
  import olid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // position, value
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // op
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // found_position, read_value,
                                                 // list_length, is_empty
  output logic [OUT_USER_W-1:0]      out_tuser   // status
);

  cell_cmd_t         cmd;
  res_t              res;
  logic              res_valid;
  logic              out_free;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] cell_data [CAPACITY];

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  in_acc;
  logic                  ins_ok;
  logic                  clr_acc;
  logic                  res_cleared;

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  // sequencer
  olid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[OP_W-1:0]),
    .in_pos    (in_tdata[POS_W-1:0]),
    .in_value  (in_tdata[POS_W+WORD_W-1:POS_W]),
    .head      (cell_data[0]),
    .out_free  (out_free),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .list_len  (cnt)
  );

  // chain of entry cells, the last one wraps to the head for rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_data;
    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end
    olid_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_data),
      .right_data (cell_data[(i + 1) % CAPACITY]),
      .data_o     (cell_data[i])
    );
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_data_r <= {res.empty, res.len, res.rd, res.found};
      out_user_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // check terms: legal insert beat, clear beat, cleared result
  assign ins_ok      = in_acc && (in_tuser[OP_W-1:0] == OP_INSERT)
                       && (cnt < CNT_W'(CAPACITY))
                       && (CMP_W'(in_tdata[POS_W-1:0]) <= CMP_W'(cnt));
  assign clr_acc     = in_acc && (in_tuser[OP_W-1:0] == OP_CLEAR);
  assign res_cleared = res_valid && res.empty && (res.status == ST_OK);

  // checks
  `OLID_ASSERT_NXT(a_insert_grows, clk, rst_n, ins_ok, res_valid && (cnt == $past(cnt) + CNT_W'(1)))
  `OLID_ASSERT_NXT(a_clear_empties, clk, rst_n, clr_acc, res_cleared)
  `OLID_ASSERT_NXT(a_result_held, clk, rst_n, res_valid && !out_free, res_valid && $stable(res))

endmodule

`default_nettype wire
